### sv/mbps_pkg.sv
// Shared types, constants and helpers of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int DATA_W          = 8;
    localparam int ADDR_W          = 64;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int CARE_W          = 16;
    localparam int LEN_W           = 5;
    localparam int PAT_W           = 2 * CFG_DATA_W;
    localparam int PAT_IDX_W       = 4;
    localparam int S_TDATA_W       = DATA_W + ADDR_W;
    localparam int S_TUSER_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd3;

    // Per-cycle control handed to every window cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } result_t;

    function automatic logic [DATA_W-1:0] pattern_byte(
        input logic [PAT_W-1:0]     pattern,
        input logic [PAT_IDX_W-1:0] sel
    );
        return pattern[sel*DATA_W +: DATA_W];
    endfunction

endpackage

### sv/mbps_cell.sv
// One window cell: holds one byte of the window and checks it against its pattern byte.
`timescale 1ns / 1ps

module mbps_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                         aclk,
    input  mbps_pkg::cell_ctrl_t         ctrl,
    input  logic [mbps_pkg::DATA_W-1:0]  byte_in,
    input  logic [mbps_pkg::LEN_W-1:0]   eff_len,
    input  logic [mbps_pkg::PAT_W-1:0]   pattern,
    input  logic [mbps_pkg::CARE_W-1:0]  care_mask,
    output logic [mbps_pkg::DATA_W-1:0]  byte_out,
    output logic                         match_ok
);
    import mbps_pkg::*;

    localparam logic [LEN_W-1:0] POS = LEN_W'(CELL_IDX);

    logic [DATA_W-1:0]    byte_reg;
    logic [DATA_W-1:0]    byte_next;
    logic [DATA_W-1:0]    byte_held;
    logic [LEN_W-1:0]     slot;
    logic [PAT_IDX_W-1:0] sel;
    logic                 active;

    // A cleared window hands zeros to the neighbor in the same cycle.
    assign byte_held = ctrl.clear ? '0 : byte_reg;
    assign byte_next = ctrl.shift ? byte_in : byte_held;
    assign byte_out  = byte_held;

    // The newest byte lines up with the last pattern byte in use.
    assign active = POS < eff_len;
    assign slot   = eff_len - POS - LEN_W'(1);
    assign sel    = slot[PAT_IDX_W-1:0];

    assign match_ok = !active || !care_mask[sel] ||
                      (byte_next == pattern_byte(pattern, sel));

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

### sv/mbps_out_buf.sv
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps

module mbps_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  mbps_pkg::result_t in_res,
    output logic              in_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output mbps_pkg::result_t m_res
);
    import mbps_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        // New words only arrive while the skid stage is empty.
        if (in_valid) begin
            if (!out_valid_next) begin
                out_next       = in_res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = in_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

endmodule

### sv/masked_byte_pattern_scanner.sv
// Latency: a result word is on m_tvalid in the cycle after the input word that causes it, unless the
// word ahead stalls; then it waits in the skid stage. Throughput: one input word per cycle while s_tready
// is high; the row of window cells shifts and compares every byte together, and a skid stage keeps
// s_tready high while one result waits. Reset (aresetn low, synchronous): configuration returns to its
// reset values, the window fill count and the found flag clear, and the result channel empties.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbps_pkg::S_TDATA_W-1:0]    s_tdata,   // data_byte, byte_address
    input  logic [mbps_pkg::S_TUSER_W-1:0]    s_tuser,   // new_scan, run_start
    input  logic                              s_tlast,   // region_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbps_pkg::ADDR_W-1:0]       m_tdata,   // match_address
    output logic                              m_tuser    // match_found
);
    import mbps_pkg::*;

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(PATTERN_MAX);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [CARE_W-1:0]     care_mask_reg;
    logic [LEN_W-1:0]      pattern_len_reg;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              found_reg, found_next;

    logic [DATA_W-1:0] data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              new_scan, run_start, region_end;

    logic              accept, found_eff, window_clear, match;
    logic [LEN_W-1:0]  eff_len;
    logic [FILL_W-1:0] fill_base, fill_inc;
    logic [PAT_W-1:0]  pattern;
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cell_ok;
    logic              res_valid;
    result_t           res, m_res;

    assign data_byte    = s_tdata[DATA_W-1:0];
    assign byte_address = s_tdata[DATA_W +: ADDR_W];
    assign new_scan     = s_tuser[0];
    assign run_start    = s_tuser[1];
    assign region_end   = s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_mask_reg    <= '0;
            pattern_len_reg  <= LEN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_wr_data;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_wr_data;
                REG_CARE_MASK:    care_mask_reg    <= cfg_wr_data[CARE_W-1:0];
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_wr_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pattern_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (pattern_len_reg > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = pattern_len_reg;
        end
    end

    assign pattern = {pattern_high_reg, pattern_low_reg};

    // A new scan is applied before the found flag is looked at.
    assign accept       = s_tvalid && s_tready;
    assign found_eff    = new_scan ? 1'b0 : found_reg;
    assign window_clear = new_scan || run_start;
    assign ctrl.clear   = accept && window_clear;
    assign ctrl.shift   = accept && !found_eff;

    assign chain[0] = data_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        mbps_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .byte_in   (chain[k]),
            .eff_len   (eff_len),
            .pattern   (pattern),
            .care_mask (care_mask_reg),
            .byte_out  (chain[k+1]),
            .match_ok  (cell_ok[k])
        );
    end

    assign fill_base = window_clear ? '0 : fill_reg;
    assign fill_inc  = (fill_base < FILL_MAX) ? fill_base + FILL_W'(1) : fill_base;
    assign match     = (LEN_W'(fill_inc) >= eff_len) && (&cell_ok);

    assign res_valid = ctrl.shift && (match || region_end);
    assign res.found = match;
    assign res.addr  = match ? byte_address - ADDR_W'(eff_len - LEN_W'(1)) : '0;

    always_comb begin
        fill_next  = fill_reg;
        found_next = found_reg;
        if (accept) begin
            fill_next  = ctrl.shift ? fill_inc : fill_base;
            found_next = found_eff || res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            found_reg <= found_next;
        end
    end

    mbps_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (s_tready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = m_res.addr;
    assign m_tuser = m_res.found;

    a_found_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_valid) |=> found_reg)
        else $error("found flag not set after a result");

    a_not_found_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result carries a nonzero address");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("window fill count beyond window depth");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while the output register is empty");

endmodule
